// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== sv/cft_pkg.sv =====
`timescale 1ns / 1ps

package cft_pkg;

    localparam int BYTE_W       = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int CFT_QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] LF_BYTE = 8'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIM  = 2'd2;

    localparam logic [BYTE_W-1:0] QUOTE_RESET  = 8'd34;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd92;
    localparam logic [BYTE_W-1:0] DELIM_RESET  = 8'd44;

    // A text byte together with its classification.
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              is_lf;
        logic              is_quote;
        logic              is_escape;
        logic              is_delim;
    } cls_t;

    // One result request.
    typedef struct packed {
        logic [BYTE_W-1:0] field_byte;
        logic              byte_valid;
        logic              field_end;
        logic              row_end;
        logic              quote_error;
    } res_t;

endpackage

// ===== sv/csv_field_tokenizer.sv =====
`timescale 1ns / 1ps

// Streaming CSV tokenizer: it takes one text byte per cycle while full is low
// and yields field bytes, end-of-field and end-of-row marks, and a flag for a
// quoted field left open at a line end. The sustained rate is one byte per
// clock, set by the parser state update in the back end, which handles one
// classified byte per cycle while a byte waits and the result queue is not
// full. A byte is held in the first queue and its result in the result queue
// before it reaches the output ports; bytes that yield no result are consumed
// silently. Two queues of QUEUE_DEPTH entries separate the input, the parser
// and the output, so either side may stall without stopping the other at once.
module csv_field_tokenizer
    import cft_pkg::*;
#(
    parameter int QUEUE_DEPTH = CFT_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [BYTE_W-1:0]      text_byte,
    output logic                   empty,
    input  logic                   pop,
    output logic [BYTE_W-1:0]      field_byte,
    output logic                   byte_valid,
    output logic                   field_end,
    output logic                   row_end,
    output logic                   quote_error
);

    cls_t front_item;
    cls_t mid_item;
    logic mid_empty;
    logic mid_pop;
    logic res_full;
    logic res_push;
    res_t back_res;
    res_t head_res;

    cft_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text_byte (text_byte),
        .item      (front_item)
    );

    cft_fifo #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (front_item),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata (mid_item)
    );

    cft_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (mid_empty),
        .in_item  (mid_item),
        .in_pop   (mid_pop),
        .out_full (res_full),
        .out_push (res_push),
        .out_res  (back_res)
    );

    cft_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (back_res),
        .pop   (pop),
        .empty (empty),
        .rdata (head_res)
    );

    assign field_byte  = head_res.field_byte;
    assign byte_valid  = head_res.byte_valid;
    assign field_end   = head_res.field_end;
    assign row_end     = head_res.row_end;
    assign quote_error = head_res.quote_error;

endmodule

// ===== sv/cft_fifo.sv =====
`timescale 1ns / 1ps

module cft_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/cft_front.sv =====
`timescale 1ns / 1ps

module cft_front
    import cft_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [BYTE_W-1:0]      text_byte,
    output cls_t                   item
);

    logic [BYTE_W-1:0] quote_reg,  quote_next;
    logic [BYTE_W-1:0] escape_reg, escape_next;
    logic [BYTE_W-1:0] delim_reg,  delim_next;

    always_comb
    begin
        quote_next  = quote_reg;
        escape_next = escape_reg;
        delim_next  = delim_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_QUOTE:  quote_next  = cfg_data;
                CFG_ESCAPE: escape_next = cfg_data;
                CFG_DELIM:  delim_next  = cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg  <= QUOTE_RESET;
            escape_reg <= ESCAPE_RESET;
            delim_reg  <= DELIM_RESET;
        end
        else
        begin
            quote_reg  <= quote_next;
            escape_reg <= escape_next;
            delim_reg  <= delim_next;
        end
    end

    assign item.text_byte = text_byte;
    assign item.is_lf     = (text_byte == LF_BYTE);
    assign item.is_quote  = (text_byte == quote_reg);
    assign item.is_escape = (text_byte == escape_reg);
    assign item.is_delim  = (text_byte == delim_reg);

endmodule

// ===== sv/cft_back.sv =====
`timescale 1ns / 1ps

module cft_back
    import cft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_empty,
    input  cls_t in_item,
    output logic in_pop,
    input  logic out_full,
    output logic out_push,
    output res_t out_res
);

    typedef enum logic [6:0] {
        MODE_LINE_START = 7'b0000001,
        MODE_COL_START  = 7'b0000010,
        MODE_UNQUOTED   = 7'b0000100,
        MODE_QUOTED     = 7'b0001000,
        MODE_ESCAPED    = 7'b0010000,
        MODE_AFTER_Q    = 7'b0100000,
        MODE_SKIP       = 7'b1000000
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  emit;
        res_t  res;
    } step_t;

    function automatic res_t make_res(input logic [BYTE_W-1:0] b, input logic bv,
                                      input logic fe, input logic re, input logic qe);
        res_t r;
        r.field_byte  = bv ? b : '0;
        r.byte_valid  = bv;
        r.field_end   = fe;
        r.row_end     = re;
        r.quote_error = qe;
        return r;
    endfunction

    // A column starts here, either at line start or after a delimiter.
    function automatic step_t col_start(input cls_t it);
        step_t s;
        if (it.is_quote)
        begin
            s.mode = MODE_QUOTED;
            s.emit = 1'b0;
            s.res  = make_res('0, 1'b0, 1'b0, 1'b0, 1'b0);
        end
        else if (it.is_delim)
        begin
            s.mode = MODE_COL_START;
            s.emit = 1'b1;
            s.res  = make_res('0, 1'b0, 1'b1, 1'b0, 1'b0);
        end
        else
        begin
            s.mode = MODE_UNQUOTED;
            s.emit = 1'b1;
            s.res  = make_res(it.text_byte, 1'b1, 1'b0, 1'b0, 1'b0);
        end
        return s;
    endfunction

    mode_t mode_reg, mode_next;
    step_t step;
    logic  take;

    assign take = !in_empty && !out_full;

    always_comb
    begin
        step.mode = mode_reg;
        step.emit = 1'b0;
        step.res  = make_res('0, 1'b0, 1'b0, 1'b0, 1'b0);
        case (mode_reg)
            MODE_COL_START:
            begin
                if (in_item.is_lf)
                begin
                    step.mode = MODE_LINE_START;
                    step.emit = 1'b1;
                    step.res  = make_res('0, 1'b0, 1'b0, 1'b1, 1'b0);
                end
                else
                begin
                    step = col_start(in_item);
                end
            end
            MODE_UNQUOTED:
            begin
                step.emit = 1'b1;
                if (in_item.is_lf)
                begin
                    step.mode = MODE_LINE_START;
                    step.res  = make_res('0, 1'b0, 1'b1, 1'b1, 1'b0);
                end
                else if (in_item.is_delim)
                begin
                    step.mode = MODE_COL_START;
                    step.res  = make_res('0, 1'b0, 1'b1, 1'b0, 1'b0);
                end
                else
                begin
                    step.res = make_res(in_item.text_byte, 1'b1, 1'b0, 1'b0, 1'b0);
                end
            end
            MODE_QUOTED:
            begin
                if (in_item.is_lf)
                begin
                    step.mode = MODE_LINE_START;
                    step.emit = 1'b1;
                    step.res  = make_res('0, 1'b0, 1'b0, 1'b1, 1'b1);
                end
                else if (in_item.is_quote)
                begin
                    step.mode = MODE_AFTER_Q;
                    step.emit = 1'b1;
                    step.res  = make_res('0, 1'b0, 1'b1, 1'b0, 1'b0);
                end
                else if (in_item.is_escape)
                begin
                    step.mode = MODE_ESCAPED;
                end
                else
                begin
                    step.emit = 1'b1;
                    step.res  = make_res(in_item.text_byte, 1'b1, 1'b0, 1'b0, 1'b0);
                end
            end
            MODE_ESCAPED:
            begin
                step.mode = MODE_QUOTED;
                step.emit = 1'b1;
                step.res  = make_res(in_item.text_byte, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            MODE_AFTER_Q:
            begin
                if (in_item.is_lf)
                begin
                    step.mode = MODE_LINE_START;
                    step.emit = 1'b1;
                    step.res  = make_res('0, 1'b0, 1'b0, 1'b1, 1'b0);
                end
                else if (in_item.is_delim)
                begin
                    step.mode = MODE_COL_START;
                end
                else
                begin
                    step.mode = MODE_SKIP;
                    step.emit = 1'b1;
                    step.res  = make_res('0, 1'b0, 1'b0, 1'b1, 1'b0);
                end
            end
            MODE_SKIP:
            begin
                if (in_item.is_lf)
                begin
                    step.mode = MODE_LINE_START;
                end
            end
            default:
            begin
                if (in_item.is_lf)
                begin
                    step.mode = MODE_LINE_START;
                end
                else
                begin
                    step = col_start(in_item);
                end
            end
        endcase
    end

    assign mode_next = take ? step.mode : mode_reg;
    assign in_pop    = take;
    assign out_push  = take && step.emit;
    assign out_res   = step.res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LINE_START;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== sv/cft_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cft_checker
    import cft_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input logic [BYTE_W-1:0] field_byte,
    input logic              byte_valid,
    input logic              field_end,
    input logic              row_end,
    input logic              quote_error
);

    // A result carries either a field byte or marks, never both.
    `ASSERT_SAME(a_byte_or_mark, clk, rst_n, !empty && byte_valid, !field_end && !row_end)

    // An open quote at a line end closes the row but not the field.
    `ASSERT_SAME(a_quote_error_row, clk, rst_n, !empty && quote_error, row_end && !field_end)

    // Marks carry a zero byte.
    `ASSERT_SAME(a_mark_zero_byte, clk, rst_n, !empty && !byte_valid, field_byte == '0)

    // A waiting result is not withdrawn.
    `ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop, !empty)

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .field_byte  (field_byte),
    .byte_valid  (byte_valid),
    .field_end   (field_end),
    .row_end     (row_end),
    .quote_error (quote_error)
);
